// ===== rtl/kf_pkg.sv =====
// Shared constants and types for the scalar Kalman filter.
// Used by kf_mul, kf_div and scalar_kalman_filter; no dependencies.
`timescale 1ns / 1ps

package kf_pkg;

  localparam int DEF_WORD_BITS  = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int MUL_DIGIT_BITS = 16;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_TRANSITION_GAIN   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROCESS_NOISE     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEASUREMENT_NOISE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_ESTIMATE  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_VARIANCE  = 3'd4;

  // status of an iterative arithmetic unit as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ===== rtl/kf_mul.sv =====
// Iterative unsigned multiplier: one digit of op_b per cycle, MSB digit first.
// Depends on kf_pkg for the default digit width and the status struct.
`timescale 1ns / 1ps

module kf_mul
  import kf_pkg::*;
#(
  parameter int OP_BITS    = DEF_WORD_BITS + 1,
  parameter int DIGIT_BITS = MUL_DIGIT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [OP_BITS-1:0]     op_a,
  input  logic [OP_BITS-1:0]     op_b,
  output logic [2*OP_BITS-1:0]   product,
  output unit_sts_t              sts
);

  localparam int STEPS     = (OP_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PAD_BITS  = STEPS * DIGIT_BITS;
  localparam int CNT_BITS  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int PART_BITS = OP_BITS + DIGIT_BITS;
  localparam int PROD_BITS = 2 * OP_BITS;
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(STEPS - 1);

  logic [OP_BITS-1:0]    a_r;
  logic [PAD_BITS-1:0]   b_r;
  logic [PROD_BITS-1:0]  acc_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIGIT_BITS-1:0] digit;
  logic [PART_BITS-1:0]  part;

  assign digit = b_r[PAD_BITS-1 -: DIGIT_BITS];
  assign part  = PART_BITS'(a_r) * PART_BITS'(digit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_BITS'(1);
        end
      end
    end
  end

  // shift the partial sum up one digit and add the next digit's partial product
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= PAD_BITS'(op_b);
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << DIGIT_BITS) + PROD_BITS'(part);
      b_r   <= b_r << DIGIT_BITS;
    end
  end

  assign product  = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== rtl/kf_div.sv =====
// Restoring divider for the gain: floor((num << FRAC_BITS) / den), num <= den.
// One quotient bit per cycle; depends on kf_pkg for defaults and the status struct.
`timescale 1ns / 1ps

module kf_div
  import kf_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] num,
  input  logic [WORD_BITS:0]   den,
  output logic [FRAC_BITS:0]   quot,
  output unit_sts_t            sts
);

  localparam int REM_BITS = WORD_BITS + 2;
  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(FRAC_BITS);

  logic [REM_BITS-1:0]  rem_r;
  logic [WORD_BITS:0]   den_r;
  logic [FRAC_BITS:0]   q_r;
  logic                 zero_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [REM_BITS-1:0]  diff;
  logic                 ge;

  assign ge   = rem_r >= REM_BITS'(den_r);
  assign diff = rem_r - REM_BITS'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_BITS'(1);
        end
      end
    end
  end

  // compare, subtract when it fits, then shift the remainder for the next bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= REM_BITS'(num);
      den_r  <= den;
      q_r    <= '0;
      zero_r <= (den == '0);
    end else if (busy_r) begin
      rem_r <= (ge ? diff : rem_r) << 1;
      q_r   <= {q_r[FRAC_BITS-1:0], ge};
    end
  end

  assign quot     = zero_r ? '0 : q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== rtl/scalar_kalman_filter.sv =====
// Scalar (one-dimensional) Kalman filter in signed fixed point, Q16.16 by default.
// Each observation request runs predict (x = F*x, P = F*F*P + Q) and update
// (K = P/(P+R), x += K*(obs - x), P *= 1 - K), and returns the new estimate,
// variance, gain and a saturation flag. All five products go through one
// shared digit-serial multiplier (kf_mul) and the gain through one restoring
// divider (kf_div), both stepped by the sequencer in this module. in_stall
// stays high from accept until the result moves into the output register,
// through the five multiplier passes and the FRAC_BITS+1 divider steps, and
// while a full output register holds the result back. A finished result
// waits in the output register while the next request
// is accepted. A restart bit on a request reloads the estimate and variance
// from the initial-value registers first. Estimate and predicted variance
// clamp to their word ranges and out_saturated reports it. Configuration
// registers (index 0..4: F, Q, R, initial estimate, initial variance; other
// indexes are dropped) are written through cfg_valid/cfg_ready, which is
// always ready; write them only while no request is in flight.
`timescale 1ns / 1ps

module scalar_kalman_filter
  import kf_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [WORD_BITS-1:0]        cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] in_observation,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_estimate,
  output logic [WORD_BITS-1:0]        out_error_variance,
  output logic [FRAC_BITS:0]          out_kalman_gain,
  output logic                        out_saturated
);

  localparam int OP_BITS   = WORD_BITS + 1;
  localparam int PROD_BITS = 2 * OP_BITS;
  localparam int SUM_BITS  = WORD_BITS + 2;

  localparam logic [FRAC_BITS:0]   ONE_Q    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(ONE_Q);
  localparam logic [WORD_BITS-1:0] WORD_MAX = '1;
  localparam logic [WORD_BITS-1:0] SMAX_W   = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SMIN_W   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [PROD_BITS-1:0] HALF_Q   = PROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_BITS-1:0] POS_LIM  = PROD_BITS'(SMAX_W);
  localparam logic [PROD_BITS-1:0] NEG_LIM  = PROD_BITS'(SMIN_W);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MFX  = 4'd1;  // F * x
  localparam logic [3:0] S_MFF  = 4'd2;  // F * F
  localparam logic [3:0] S_MFP  = 4'd3;  // F^2 * P
  localparam logic [3:0] S_ADDQ = 4'd4;  // P + Q, innovation
  localparam logic [3:0] S_DIV  = 4'd5;  // P / (P + R)
  localparam logic [3:0] S_MKY  = 4'd6;  // K * innovation
  localparam logic [3:0] S_MPV  = 4'd7;  // P * (1 - K)
  localparam logic [3:0] S_EST  = 4'd8;  // x + correction
  localparam logic [3:0] S_OUT  = 4'd9;  // hand result to output register

  // configuration registers
  logic [WORD_BITS-1:0] tg_r, qn_r, rn_r, ie_r, iv_r;

  // filter state and per-request working registers
  logic [3:0]           state_r, state_nxt;
  logic                 start_r, start_nxt;
  logic [WORD_BITS-1:0] est_r, est_nxt;
  logic [WORD_BITS-1:0] var_r, var_nxt;
  logic [WORD_BITS-1:0] obs_r, obs_nxt;
  logic [WORD_BITS-1:0] xp_r, xp_nxt;
  logic [WORD_BITS-1:0] f2_r, f2_nxt;
  logic [WORD_BITS-1:0] pp_r, pp_nxt;
  logic [FRAC_BITS:0]   gain_r, gain_nxt;
  logic [OP_BITS-1:0]   ymag_r, ymag_nxt;
  logic                 yneg_r, yneg_nxt;
  logic [OP_BITS-1:0]   corr_r, corr_nxt;
  logic                 sat_r, sat_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] oest_r, oest_nxt;
  logic [WORD_BITS-1:0] ovar_r, ovar_nxt;
  logic [FRAC_BITS:0]   ogain_r, ogain_nxt;
  logic                 osat_r, osat_nxt;

  // arithmetic units
  logic                 mul_start, div_start;
  logic [OP_BITS-1:0]   mul_a, mul_b;
  logic [PROD_BITS-1:0] mul_prod;
  unit_sts_t            mul_sts, div_sts;
  logic [WORD_BITS:0]   div_den;
  logic [FRAC_BITS:0]   div_quot;

  // datapath helpers
  logic                 f_neg, x_neg, px_neg;
  logic [WORD_BITS-1:0] f_mag, x_mag;
  logic [PROD_BITS-1:0] rq;
  logic [WORD_BITS-1:0] rq_clamp;
  logic                 rq_over;
  logic [WORD_BITS:0]   q_sum;
  logic [WORD_BITS:0]   y_sum;
  logic [SUM_BITS-1:0]  x_ext, c_ext, e_sum;
  logic                 e_over;
  logic                 in_acc, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // sign and magnitude of F and the current estimate
  assign f_neg  = tg_r[WORD_BITS-1];
  assign x_neg  = est_r[WORD_BITS-1];
  assign f_mag  = f_neg ? (~tg_r + WORD_BITS'(1)) : tg_r;
  assign x_mag  = x_neg ? (~est_r + WORD_BITS'(1)) : est_r;
  assign px_neg = f_neg ^ x_neg;

  // round the product to nearest, ties away from zero, and drop the fraction
  assign rq       = (mul_prod + HALF_Q) >> FRAC_BITS;
  assign rq_over  = |rq[PROD_BITS-1:WORD_BITS];
  assign rq_clamp = rq_over ? WORD_MAX : rq[WORD_BITS-1:0];

  assign q_sum   = {1'b0, pp_r} + {1'b0, qn_r};
  assign div_den = {1'b0, pp_r} + {1'b0, rn_r};
  assign y_sum   = {obs_r[WORD_BITS-1], obs_r} - {xp_r[WORD_BITS-1], xp_r};

  // new estimate: predicted estimate plus signed correction, exact
  assign x_ext  = {{2{xp_r[WORD_BITS-1]}}, xp_r};
  assign c_ext  = yneg_r ? (~{1'b0, corr_r} + SUM_BITS'(1)) : {1'b0, corr_r};
  assign e_sum  = x_ext + c_ext;
  assign e_over = !((e_sum[SUM_BITS-1:WORD_BITS-1] == '0) ||
                    (e_sum[SUM_BITS-1:WORD_BITS-1] == '1));

  assign mul_start = start_r && (state_r == S_MFX || state_r == S_MFF ||
                                 state_r == S_MFP || state_r == S_MKY ||
                                 state_r == S_MPV);
  assign div_start = start_r && (state_r == S_DIV);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MFX: begin
        mul_a = OP_BITS'(f_mag);
        mul_b = OP_BITS'(x_mag);
      end
      S_MFF: begin
        mul_a = OP_BITS'(f_mag);
        mul_b = OP_BITS'(f_mag);
      end
      S_MFP: begin
        mul_a = OP_BITS'(f2_r);
        mul_b = OP_BITS'(var_r);
      end
      S_MKY: begin
        mul_a = ymag_r;
        mul_b = OP_BITS'(gain_r);
      end
      S_MPV: begin
        mul_a = OP_BITS'(pp_r);
        mul_b = OP_BITS'(ONE_Q - gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    est_nxt       = est_r;
    var_nxt       = var_r;
    obs_nxt       = obs_r;
    xp_nxt        = xp_r;
    f2_nxt        = f2_r;
    pp_nxt        = pp_r;
    gain_nxt      = gain_r;
    ymag_nxt      = ymag_r;
    yneg_nxt      = yneg_r;
    corr_nxt      = corr_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    oest_nxt      = oest_r;
    ovar_nxt      = ovar_r;
    ogain_nxt     = ogain_r;
    osat_nxt      = osat_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          obs_nxt   = in_observation;
          sat_nxt   = 1'b0;
          state_nxt = S_MFX;
          start_nxt = 1'b1;
          if (in_restart) begin
            est_nxt = ie_r;
            var_nxt = iv_r;
          end
        end
      end
      S_MFX: begin
        if (mul_sts.done) begin
          // clamp the signed predicted estimate
          if (!px_neg && rq > POS_LIM) begin
            xp_nxt  = SMAX_W;
            sat_nxt = 1'b1;
          end else if (px_neg && rq > NEG_LIM) begin
            xp_nxt  = SMIN_W;
            sat_nxt = 1'b1;
          end else if (px_neg) begin
            xp_nxt = ~rq[WORD_BITS-1:0] + WORD_BITS'(1);
          end else begin
            xp_nxt = rq[WORD_BITS-1:0];
          end
          state_nxt = S_MFF;
          start_nxt = 1'b1;
        end
      end
      S_MFF: begin
        if (mul_sts.done) begin
          f2_nxt    = rq_clamp;
          sat_nxt   = sat_r || rq_over;
          state_nxt = S_MFP;
          start_nxt = 1'b1;
        end
      end
      S_MFP: begin
        if (mul_sts.done) begin
          pp_nxt    = rq_clamp;
          sat_nxt   = sat_r || rq_over;
          state_nxt = S_ADDQ;
        end
      end
      S_ADDQ: begin
        // add Q with saturation; form the innovation alongside
        if (q_sum[WORD_BITS]) begin
          pp_nxt  = WORD_MAX;
          sat_nxt = 1'b1;
        end else begin
          pp_nxt = q_sum[WORD_BITS-1:0];
        end
        yneg_nxt  = y_sum[WORD_BITS];
        ymag_nxt  = y_sum[WORD_BITS] ? (~y_sum + OP_BITS'(1)) : y_sum;
        state_nxt = S_DIV;
        start_nxt = 1'b1;
      end
      S_DIV: begin
        if (div_sts.done) begin
          gain_nxt  = div_quot;
          state_nxt = S_MKY;
          start_nxt = 1'b1;
        end
      end
      S_MKY: begin
        if (mul_sts.done) begin
          corr_nxt  = rq[OP_BITS-1:0];
          state_nxt = S_MPV;
          start_nxt = 1'b1;
        end
      end
      S_MPV: begin
        if (mul_sts.done) begin
          var_nxt   = rq_clamp;
          state_nxt = S_EST;
        end
      end
      S_EST: begin
        if (e_over) begin
          est_nxt = e_sum[SUM_BITS-1] ? SMIN_W : SMAX_W;
          sat_nxt = 1'b1;
        end else begin
          est_nxt = e_sum[WORD_BITS-1:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oest_nxt      = est_r;
          ovar_nxt      = var_r;
          ogain_nxt     = gain_r;
          osat_nxt      = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state, filter state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      est_r       <= '0;
      var_r       <= WORD_ONE;
      tg_r        <= WORD_ONE;
      qn_r        <= '0;
      rn_r        <= WORD_ONE;
      ie_r        <= '0;
      iv_r        <= WORD_ONE;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TRANSITION_GAIN:   tg_r <= cfg_data;
          REG_PROCESS_NOISE:     qn_r <= cfg_data;
          REG_MEASUREMENT_NOISE: rn_r <= cfg_data;
          REG_INITIAL_ESTIMATE:  ie_r <= cfg_data;
          REG_INITIAL_VARIANCE:  iv_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    obs_r   <= obs_nxt;
    xp_r    <= xp_nxt;
    f2_r    <= f2_nxt;
    pp_r    <= pp_nxt;
    gain_r  <= gain_nxt;
    ymag_r  <= ymag_nxt;
    yneg_r  <= yneg_nxt;
    corr_r  <= corr_nxt;
    sat_r   <= sat_nxt;
    oest_r  <= oest_nxt;
    ovar_r  <= ovar_nxt;
    ogain_r <= ogain_nxt;
    osat_r  <= osat_nxt;
  end

  kf_mul #(
    .OP_BITS    (OP_BITS),
    .DIGIT_BITS (MUL_DIGIT_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (mul_prod),
    .sts     (mul_sts)
  );

  kf_div #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (pp_r),
    .den   (div_den),
    .quot  (div_quot),
    .sts   (div_sts)
  );

  assign out_valid          = out_valid_r;
  assign out_estimate       = oest_r;
  assign out_error_variance = ovar_r;
  assign out_kalman_gain    = ogain_r;
  assign out_saturated      = osat_r;

  // the multiplier and divider never run at the same time
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  // an accepted request launches the first product on the next cycle
  a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MFX && start_r))
    else $error("accepted request did not start predict");

  // multiplier completions arrive only while a product is awaited
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> (state_r == S_MFX || state_r == S_MFF || state_r == S_MFP ||
                      state_r == S_MKY || state_r == S_MPV))
    else $error("multiplier done outside a product state");

  // the gain handed out never exceeds one
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kalman_gain <= ONE_Q))
    else $error("gain above one");

endmodule
